// File: rtl/tts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tridiagonal solver package
// Shared types, constants and command/status structs.
// ----------------------------------------------------------------------------
package tts_pkg;

   localparam int DefaultMaxRows = 64;
   localparam int DefaultFracBits = 16;
   localparam int DataWidth = 32;
   localparam int IndexWidth = 6;

   typedef struct packed {
      logic signed [31:0] sub_diag;
      logic signed [31:0] main_diag;
      logic signed [31:0] super_diag;
      logic signed [31:0] rhs;
      logic               last_row;
   } req_type;

   typedef struct packed {
      logic signed [31:0] solution;
      logic [5:0]         row_index;
      logic               last_solution;
      logic               pivot_error;
   } rsp_type;

   typedef struct packed {
      logic load_row;     // capture the incoming row
      logic start_pivot;  // compute pivot and numerator products
      logic finish_pivot; // register pivot and numerator
      logic start_div_c;  // start divider on c / pivot
      logic start_div_d;  // start divider on num / pivot
      logic store_c;      // latch c' result
      logic store_d;      // latch d' result and write stores
      logic start_back;   // begin back substitution
      logic back_read;    // read store entry
      logic back_mul;     // multiply stage
      logic back_emit;    // produce solution into output register
      logic clear_sys;    // end of system
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic row_last;     // current row is final
      logic back_done;    // current back index is zero
      logic out_full;
   } sts_type;

endpackage

// File: rtl/tts_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterative fixed-point divider
// Restoring division of (num << FRAC_BITS) by den, one quotient bit a cycle,
// saturated to 32 bits with an overflow flag.
// ----------------------------------------------------------------------------
module tts_divider
   import tts_pkg::*;
#(
   parameter int FRAC_BITS = DefaultFracBits
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] num,
   input  logic signed [31:0] den,
   output logic               busy,
   output logic signed [31:0] quot,
   output logic               ovf
);

   localparam int NumWidth = 32 + FRAC_BITS;
   localparam int CntWidth = $clog2(NumWidth + 1);

   logic [NumWidth-1:0] dvd_ff, dvd_in;
   logic [31:0]         dvs_ff, dvs_in;
   logic [32:0]         rem_ff, rem_in;
   logic [NumWidth-1:0] q_ff, q_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                neg_ff, neg_in;
   logic                zero_ff, zero_in;
   logic                nsgn_ff, nsgn_in;
   logic                nzero_ff, nzero_in;
   logic [32:0]         shifted;
   logic [32:0]         diff;
   logic [NumWidth:0]   mag;
   logic [31:0]         num_abs;
   logic [31:0]         den_abs;

   assign num_abs = num[31] ? 32'(-num) : 32'(num);
   assign den_abs = den[31] ? 32'(-den) : 32'(den);
   assign shifted = {rem_ff[31:0], dvd_ff[NumWidth-1]};
   assign diff = shifted - {1'b0, dvs_ff};

   always_comb begin
      dvd_in = dvd_ff;
      dvs_in = dvs_ff;
      rem_in = rem_ff;
      q_in = q_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      neg_in = neg_ff;
      zero_in = zero_ff;
      nsgn_in = nsgn_ff;
      nzero_in = nzero_ff;
      if (start) begin
         dvd_in = {num_abs, {FRAC_BITS{1'b0}}};
         dvs_in = den_abs;
         rem_in = '0;
         q_in = '0;
         cnt_in = CntWidth'(NumWidth);
         busy_in = (den != 0);
         neg_in = num[31] ^ den[31];
         zero_in = (den == 0);
         nsgn_in = num[31];
         nzero_in = (num == 0);
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[NumWidth-2:0], 1'b0};
         if (!diff[32]) begin
            rem_in = diff;
            q_in = {q_ff[NumWidth-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            q_in = {q_ff[NumWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntWidth'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      q_ff <= q_in;
      neg_ff <= neg_in;
      zero_ff <= zero_in;
      nsgn_ff <= nsgn_in;
      nzero_ff <= nzero_in;
   end

   assign busy = busy_ff;
   assign mag = {1'b0, q_ff};

   always_comb begin
      ovf = 1'b0;
      quot = '0;
      if (zero_ff) begin
         ovf = 1'b1;
         if (nzero_ff) quot = '0;
         else if (nsgn_ff) quot = 32'sh8000_0000;
         else quot = 32'sh7fff_ffff;
      end else if (neg_ff) begin
         if (mag > (NumWidth+1)'(33'h0_8000_0000)) begin
            ovf = 1'b1;
            quot = 32'sh8000_0000;
         end else begin
            quot = 32'(-mag);
         end
      end else begin
         if (mag > (NumWidth+1)'(32'h7fff_ffff)) begin
            ovf = 1'b1;
            quot = 32'sh7fff_ffff;
         end else begin
            quot = 32'(mag);
         end
      end
   end

endmodule

// File: rtl/tts_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tridiagonal solver datapath
// Forward sweep arithmetic, row stores, back substitution and output register.
// ----------------------------------------------------------------------------
module tts_datapath
   import tts_pkg::*;
#(
   parameter int MAX_ROWS = DefaultMaxRows,
   parameter int FRAC_BITS = DefaultFracBits
) (
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   output sts_type sts,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int AddrWidth = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CntWidth = $clog2(MAX_ROWS + 1);

   logic signed [31:0] c_mem [MAX_ROWS];
   logic signed [31:0] d_mem [MAX_ROWS];

   req_type             row_ff;
   logic [CntWidth-1:0] count_ff, count_in;
   logic [AddrWidth-1:0] idx_ff;
   logic signed [31:0]  pc_ff, pd_ff;
   logic signed [63:0]  pa_ff, pb_ff;
   logic signed [31:0]  piv_ff, numr_ff;
   logic signed [31:0]  cm_ff;
   logic                err_ff;
   logic                last_ff;
   logic [AddrWidth-1:0] bk_ff;
   logic signed [31:0]  rc_ff, rd_ff;
   logic signed [63:0]  bp_ff;
   logic signed [31:0]  next_ff;
   logic                first_ff;
   logic                ov_ff;
   rsp_type             out_ff;

   logic                div_start;
   logic signed [31:0]  div_num;
   logic                div_busy;
   logic signed [31:0]  div_q;
   logic                div_ovf;
   logic                row_last_c;

   function automatic logic signed [31:0] sat64(input logic signed [65:0] x);
      if (x > 66'sd2147483647) return 32'sh7fff_ffff;
      if (x < -66'sd2147483648) return 32'sh8000_0000;
      return 32'(x);
   endfunction

   assign count_in = count_ff + 1'b1;
   assign row_last_c = req_data.last_row
      || (count_ff >= CntWidth'(MAX_ROWS - 1));
   assign div_start = cmd.start_div_c | cmd.start_div_d;
   assign div_num = cmd.start_div_c ? row_ff.super_diag : numr_ff;

   tts_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num),
      .den(piv_ff), .busy(div_busy), .quot(div_q), .ovf(div_ovf)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         err_ff <= 1'b0;
         rsp_valid <= 1'b0;
         pc_ff <= '0;
         pd_ff <= '0;
         first_ff <= 1'b1;
      end else begin
         if (cmd.load_row) begin
            row_ff <= req_data;
            last_ff <= row_last_c;
            idx_ff <= (count_ff >= CntWidth'(MAX_ROWS - 1)) ?
               AddrWidth'(MAX_ROWS - 1) : AddrWidth'(count_ff);
            if (!row_last_c) count_ff <= count_in;
         end
         if (cmd.start_pivot) begin
            pa_ff <= 64'(row_ff.sub_diag) * 64'(pc_ff);
            pb_ff <= 64'(row_ff.sub_diag) * 64'(pd_ff);
         end
         if (cmd.finish_pivot) begin
            if (idx_ff == '0) begin
               piv_ff <= row_ff.main_diag;
               numr_ff <= row_ff.rhs;
            end else begin
               piv_ff <= sat64(66'(row_ff.main_diag) - 66'(pa_ff >>> FRAC_BITS));
               numr_ff <= sat64(66'(row_ff.rhs) - 66'(pb_ff >>> FRAC_BITS));
            end
         end
         if (cmd.store_c) begin
            cm_ff <= last_ff ? 32'sd0 : div_q;
            if (!last_ff && div_ovf) err_ff <= 1'b1;
         end
         if (cmd.store_d) begin
            c_mem[idx_ff] <= cm_ff;
            d_mem[idx_ff] <= div_q;
            pc_ff <= cm_ff;
            pd_ff <= div_q;
            next_ff <= div_q;
            ov_ff <= err_ff | div_ovf;
            if (div_ovf) err_ff <= 1'b1;
         end
         if (cmd.start_back) begin
            bk_ff <= idx_ff;
            first_ff <= 1'b1;
         end
         if (cmd.back_read) begin
            rc_ff <= c_mem[bk_ff];
            rd_ff <= d_mem[bk_ff];
         end
         if (cmd.back_mul) begin
            bp_ff <= 64'(rc_ff) * 64'(next_ff);
         end
         if (cmd.back_emit) begin
            if (!first_ff) begin
               next_ff <= sat64(66'(rd_ff) - 66'(bp_ff >>> FRAC_BITS));
               out_ff.solution <= sat64(66'(rd_ff) - 66'(bp_ff >>> FRAC_BITS));
            end else begin
               out_ff.solution <= next_ff;
            end
            first_ff <= 1'b0;
            out_ff.row_index <= 6'(bk_ff);
            out_ff.last_solution <= (bk_ff == '0);
            out_ff.pivot_error <= ov_ff;
            rsp_valid <= 1'b1;
            if (bk_ff != '0) bk_ff <= bk_ff - 1'b1;
         end else if (rsp_valid && !rsp_stall) begin
            rsp_valid <= 1'b0;
         end
         if (cmd.clear_sys) begin
            count_ff <= '0;
            err_ff <= 1'b0;
            pc_ff <= '0;
            pd_ff <= '0;
         end
      end
   end

   assign rsp_data = out_ff;
   assign sts.div_busy = div_busy;
   assign sts.row_last = last_ff;
   assign sts.back_done = (bk_ff == '0);
   assign sts.out_full = rsp_valid & rsp_stall;

endmodule

// File: rtl/tts_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tridiagonal solver controller
// Sequences row intake, division, store writes and back substitution.
// ----------------------------------------------------------------------------
module tts_controller
   import tts_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output cmd_type cmd,
   input  sts_type sts
);

   typedef enum logic [11:0] {
      ST_IDLE   = 12'b0000_0000_0001,
      ST_MUL    = 12'b0000_0000_0010,
      ST_PIV    = 12'b0000_0000_0100,
      ST_DIVC   = 12'b0000_0000_1000,
      ST_WAITC  = 12'b0000_0001_0000,
      ST_DIVD   = 12'b0000_0010_0000,
      ST_WAITD  = 12'b0000_0100_0000,
      ST_BSTART = 12'b0000_1000_0000,
      ST_BREAD  = 12'b0001_0000_0000,
      ST_BMUL   = 12'b0010_0000_0000,
      ST_BEMIT  = 12'b0100_0000_0000,
      ST_DONE   = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_row = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.start_pivot = 1'b1;
            state_in = ST_PIV;
         end
         ST_PIV: begin
            cmd.finish_pivot = 1'b1;
            state_in = ST_DIVC;
         end
         ST_DIVC: begin
            cmd.start_div_c = 1'b1;
            state_in = ST_WAITC;
         end
         ST_WAITC: begin
            if (!sts.div_busy) begin
               cmd.store_c = 1'b1;
               state_in = ST_DIVD;
            end
         end
         ST_DIVD: begin
            cmd.start_div_d = 1'b1;
            state_in = ST_WAITD;
         end
         ST_WAITD: begin
            if (!sts.div_busy) begin
               cmd.store_d = 1'b1;
               state_in = sts.row_last ? ST_BSTART : ST_IDLE;
            end
         end
         ST_BSTART: begin
            cmd.start_back = 1'b1;
            state_in = ST_BEMIT;
         end
         ST_BREAD: begin
            cmd.back_read = 1'b1;
            state_in = ST_BMUL;
         end
         ST_BMUL: begin
            cmd.back_mul = 1'b1;
            state_in = ST_BEMIT;
         end
         ST_BEMIT: begin
            if (!sts.out_full) begin
               cmd.back_emit = 1'b1;
               if (sts.back_done) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_BREAD;
               end
            end
         end
         ST_DONE: begin
            cmd.clear_sys = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load_row |-> state_ff == ST_IDLE) else $error("row load outside idle");
   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      cmd.back_emit |-> !sts.out_full) else $error("emit into full output");
   a_done_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |=> state_ff == ST_IDLE) else $error("done did not clear");

endmodule

// File: rtl/tridiagonal_thomas_solver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tridiagonal Thomas solver
// Solves A*v=d one row per transaction; emits the solution after the last row.
// ----------------------------------------------------------------------------
// Usage:
//   req_ carries one matrix row (a, b, c, d, last_row) per transaction.
//   rsp_ carries the solution, highest row first, last_solution on row zero.
//   Values are Q16.16 at the default FRAC_BITS. Each row passes twice
//   through the one-bit-per-cycle divider, for c' and then for d', before
//   the next transaction can be accepted. After the final row is taken,
//   the last row's result is registered first; each later result passes
//   through the read, multiply and emit states while the receiver takes
//   them. req_stall stays high until the last one is in the output
//   register and the system is cleared.
//   The output register holds a result while rsp_stall is high and the
//   substitution waits on it.
//   Reset clears the row count, error flag and controller; the row stores
//   need no clearing since only entries written in a system are read.
//   Row MAX_ROWS-1 ends the system even without last_row.
// ----------------------------------------------------------------------------
module tridiagonal_thomas_solver
   import tts_pkg::*;
#(
   parameter int MAX_ROWS = DefaultMaxRows,
   parameter int FRAC_BITS = DefaultFracBits
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type cmd;
   sts_type sts;

   tts_controller u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid),
      .req_stall(req_stall), .cmd(cmd), .sts(sts)
   );

   tts_datapath #(.MAX_ROWS(MAX_ROWS), .FRAC_BITS(FRAC_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tridiagonal solver testbench
// Streams matrix rows into the solver under random idling and stalls and
// checks every solution element against a bit-exact fixed-point predictor.
// ----------------------------------------------------------------------------
module tb
   import tts_pkg::*;
();

   class solution_board;
      rsp_type pending[$];
      int errors;
      int checked;
      logic signed [31:0] super_store[64];
      logic signed [31:0] rhs_store[64];
      int rows;
      logic signed [31:0] prev_super;
      logic signed [31:0] prev_rhs;
      bit err_flag;

      function new();
         errors = 0;
         checked = 0;
         rows = 0;
         prev_super = 0;
         prev_rhs = 0;
         err_flag = 0;
      endfunction

      function logic signed [31:0] sat(longint x);
         if (x > 64'sd2147483647) return 32'sh7fffffff;
         if (x < -64'sd2147483648) return 32'sh80000000;
         return x[31:0];
      endfunction

      function longint fmul(logic signed [31:0] x, logic signed [31:0] y);
         longint p;
         p = longint'(x) * longint'(y);
         return p >>> 16;
      endfunction

      function logic signed [31:0] fdiv(logic signed [31:0] num,
                                        logic signed [31:0] den);
         longint q;
         if (den == 0) begin
            err_flag = 1;
            if (num > 0) return 32'sh7fffffff;
            if (num < 0) return 32'sh80000000;
            return 0;
         end
         q = (longint'(num) * 65536) / longint'(den);
         if (q > 64'sd2147483647 || q < -64'sd2147483648) err_flag = 1;
         return sat(q);
      endfunction

      function void note_row(req_type r);
         int i;
         bit last;
         logic signed [31:0] pivot, num, cm, dm, v;
         rsp_type e;
         i = rows;
         last = r.last_row || (i == 63);
         if (i == 0) begin
            pivot = r.main_diag;
            num = r.rhs;
         end else begin
            pivot = sat(longint'(r.main_diag) - fmul(r.sub_diag, prev_super));
            num = sat(longint'(r.rhs) - fmul(r.sub_diag, prev_rhs));
         end
         cm = last ? 32'sd0 : fdiv(r.super_diag, pivot);
         dm = fdiv(num, pivot);
         super_store[i] = cm;
         rhs_store[i] = dm;
         prev_super = cm;
         prev_rhs = dm;
         if (!last) begin
            rows = i + 1;
            return;
         end
         v = dm;
         for (int k = i; k >= 0; k--) begin
            if (k != i) v = sat(longint'(rhs_store[k]) - fmul(super_store[k], v));
            e.solution = v;
            e.row_index = k[5:0];
            e.last_solution = (k == 0);
            e.pivot_error = err_flag;
            pending.push_back(e);
         end
         rows = 0;
         prev_super = 0;
         prev_rhs = 0;
         err_flag = 0;
      endfunction

      function void check_result(rsp_type got);
         rsp_type e;
         if (pending.size() == 0) begin
            $error("unexpected solution element: %p", got);
            errors++;
            return;
         end
         e = pending.pop_front();
         checked++;
         if (got.solution !== e.solution) begin
            $error("solution expected %h actual %h", e.solution, got.solution);
            errors++;
         end
         if (got.row_index !== e.row_index) begin
            $error("row_index expected %0d actual %0d", e.row_index, got.row_index);
            errors++;
         end
         if (got.last_solution !== e.last_solution) begin
            $error("last_solution expected %b actual %b", e.last_solution,
                   got.last_solution);
            errors++;
         end
         if (got.pivot_error !== e.pivot_error) begin
            $error("pivot_error expected %b actual %b", e.pivot_error, got.pivot_error);
            errors++;
         end
      endfunction
   endclass

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 0;
   rsp_type rsp_data;

   solution_board board = new();
   bit  calm = 0;
   bit  hold_off = 0;
   int  idle_cycles = 0;
   int  sent = 0;
   int  systems = 0;

   always #6 clock = ~clock;

   tridiagonal_thomas_solver dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_data);
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else if (hold_off) begin
         rsp_stall <= 1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(99) < 27);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 40000) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic logic [31:0] rand_val();
      case ($urandom_range(5))
         0: return $urandom;
         1: return 32'h80000000;
         2: return 32'h7fffffff;
         3: return 0;
         default: return $urandom_range(32'h00040000) - 32'h00020000;
      endcase
   endfunction

   task automatic send_row(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                           logic [31:0] d, bit last);
      req_type r;
      r.sub_diag = a;
      r.main_diag = b;
      r.super_diag = c;
      r.rhs = d;
      r.last_row = last;
      while (!calm && $urandom_range(99) < 27) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_row(r);
      sent++;
      if (board.rows == 0) systems++;
   endtask

   task automatic idle_input();
      req_valid <= 0;
      @(posedge clock);
   endtask

   task automatic send_system(int n, bit wild);
      logic [31:0] b;
      for (int i = 0; i < n; i++) begin
         b = wild ? rand_val() : ($urandom_range(32'h00080000) + 32'h00040000);
         if (!wild && $urandom_range(1)) b = -b;
         send_row(wild ? rand_val() : $urandom_range(32'h00020000) - 32'h00010000, b,
                  wild ? rand_val() : $urandom_range(32'h00020000) - 32'h00010000,
                  rand_val(), i == n - 1);
      end
   endtask

   task automatic drain();
      idle_input();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: one-row and short systems, zero pivots, extremes, overflow
      send_row(0, 32'h00010000, 0, 32'h00030000, 1);
      send_row(0, 0, 0, 32'h00010000, 1);
      send_row(0, 0, 0, 32'hffff0000, 1);
      send_row(0, 0, 0, 0, 1);
      send_row(32'h7fffffff, 32'h00000001, 32'h7fffffff, 32'h7fffffff, 1);
      send_row(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 1);
      send_row(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1);
      send_row(0, 32'h00020000, 32'h00010000, 32'h00010000, 0);
      send_row(32'h00010000, 32'h00020000, 32'h00010000, 32'h00020000, 0);
      send_row(32'h00010000, 32'h00020000, 0, 32'h00030000, 1);
      send_row(0, 32'h00010000, 32'h00010000, 32'h00010000, 0);
      send_row(32'h00010000, 32'h00010000, 0, 32'h00010000, 1);
      send_row(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000, 0);
      send_row(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 1);
      drain();
      // overflow of the row count: 64 rows with no mark
      for (int i = 0; i < 63; i++) begin
         send_row(32'h00008000, 32'h00030000, 32'h00010000, rand_val(), 0);
      end
      send_row(32'h00008000, 32'h00030000, 32'h00010000, 32'h00010000, 0);
      drain();
      // receiver holds off while rows keep coming
      hold_off = 1;
      fork
         begin
            repeat (600) @(posedge clock);
            hold_off = 0;
         end
         begin
            send_system(3, 0);
            send_system(2, 0);
         end
      join
      drain();
      while (sent < 340) begin
         calm = (sent > 200 && sent < 250);
         if ($urandom_range(9) == 0) send_system($urandom_range(64, 40), 0);
         else send_system($urandom_range(8, 1), $urandom_range(4) == 0);
         if ($urandom_range(7) == 0) drain();
      end
      calm = 0;
      drain();
      repeat (200) @(posedge clock);
      $display("Covered %0d rows in %0d systems, %0d solution elements checked.",
               sent, systems, board.checked);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule

// File: tridiagonal_thomas_solver.f
rtl/tts_pkg.sv
rtl/tts_divider.sv
rtl/tts_datapath.sv
rtl/tts_controller.sv
rtl/tridiagonal_thomas_solver.sv
bench/tb.sv
